// ----- rtl/fcv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_pkg: shared types, constants and helpers
// Widths, the twiddle table and saturation helpers for the FFT convolver.
// ----------------------------------------------------------------------------
package fcv_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = 6;    // address bits of one work memory
  localparam int LEN_W      = 7;    // length and count registers
  localparam int DW         = 48;   // one real or imaginary component
  localparam int WORD_W     = 2 * DW;
  localparam int SMP_W      = 16;
  localparam int OUT_W      = 40;
  localparam int TW_W       = 16;   // Q1.15 twiddle factor
  localparam int SPEC_W     = 31;   // spectrum width before the point product
  localparam int LG_W       = 3;

  typedef logic signed [DW-1:0] data_t;

  // Twiddle handed from the sequencer to a butterfly unit.
  typedef struct packed {
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    logic                   bypass;
  } tw_t;

  localparam logic signed [63:0] DW_MAX64 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] DW_MIN64 = -DW_MAX64 - 64'sd1;
  localparam data_t SPEC_MAX = 48'sh0000_3FFF_FFFF;
  localparam data_t SPEC_MIN = -SPEC_MAX - 48'sd1;

  // Quarter wave of sin in Q1.15, full scale held at 32767.
  function automatic logic signed [TW_W-1:0] qsin(input logic [4:0] j);
    logic signed [TW_W-1:0] v;
    case (j)
      5'd0:  v = 16'sd0;
      5'd1:  v = 16'sd3212;
      5'd2:  v = 16'sd6393;
      5'd3:  v = 16'sd9512;
      5'd4:  v = 16'sd12540;
      5'd5:  v = 16'sd15447;
      5'd6:  v = 16'sd18205;
      5'd7:  v = 16'sd20788;
      5'd8:  v = 16'sd23170;
      5'd9:  v = 16'sd25330;
      5'd10: v = 16'sd27246;
      5'd11: v = 16'sd28899;
      5'd12: v = 16'sd30274;
      5'd13: v = 16'sd31357;
      5'd14: v = 16'sd32138;
      5'd15: v = 16'sd32610;
      5'd16: v = 16'sd32767;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

  // Twiddle for index k of a 64-point circle; the inverse flips the sine.
  function automatic tw_t twiddle(input logic [4:0] k, input logic inv);
    tw_t t;
    if (k <= 5'd16) begin
      t.c = qsin(5'd16 - k);
      t.s = qsin(k);
    end else begin
      t.c = -qsin(k - 5'd16);
      t.s = qsin(5'(6'd32 - {1'b0, k}));
    end
    if (inv) begin
      t.s = -t.s;
    end
    t.bypass = (k == 5'd0);
    return t;
  endfunction

  // Clamp a wide signed value to one work component.
  function automatic data_t sat_dw(input logic signed [63:0] x);
    data_t r;
    if (x > DW_MAX64) begin
      r = DW_MAX64[DW-1:0];
    end else if (x < DW_MIN64) begin
      r = DW_MIN64[DW-1:0];
    end else begin
      r = x[DW-1:0];
    end
    return r;
  endfunction

  // Clamp a spectrum component ahead of the point product.
  function automatic logic signed [SPEC_W-1:0] sat_spec(input data_t x);
    logic signed [SPEC_W-1:0] r;
    if (x > SPEC_MAX) begin
      r = SPEC_MAX[SPEC_W-1:0];
    end else if (x < SPEC_MIN) begin
      r = SPEC_MIN[SPEC_W-1:0];
    end else begin
      r = x[SPEC_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fcv_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fcv_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/fcv_bfly.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_bfly: pipelined radix-2 butterfly
// Three register stages: twiddle products, rounding, saturated sum/difference.
// ----------------------------------------------------------------------------
module fcv_bfly (
  input  wire logic          clk,
  input  wire fcv_pkg::data_t p_re,
  input  wire fcv_pkg::data_t p_im,
  input  wire fcv_pkg::data_t q_re,
  input  wire fcv_pkg::data_t q_im,
  input  wire fcv_pkg::tw_t   tw,
  output fcv_pkg::data_t      x_re,
  output fcv_pkg::data_t      x_im,
  output fcv_pkg::data_t      y_re,
  output fcv_pkg::data_t      y_im
);

  logic signed [63:0] m_rc_r, m_is_r, m_ic_r, m_rs_r;
  fcv_pkg::data_t     p1_re_r, p1_im_r, q1_re_r, q1_im_r;
  logic               byp1_r;
  fcv_pkg::data_t     p2_re_r, p2_im_r;
  logic signed [48:0] t_re_r, t_im_r;
  logic signed [48:0] t_re_nxt, t_im_nxt;
  logic signed [64:0] s_re, s_im;
  logic signed [49:0] sum_re, sum_im, dif_re, dif_im;

  // Stage 1: the four twiddle products.
  always_ff @(posedge clk) begin
    m_rc_r  <= q_re * tw.c;
    m_is_r  <= q_im * tw.s;
    m_ic_r  <= q_im * tw.c;
    m_rs_r  <= q_re * tw.s;
    p1_re_r <= p_re;
    p1_im_r <= p_im;
    q1_re_r <= q_re;
    q1_im_r <= q_im;
    byp1_r  <= tw.bypass;
  end

  // Stage 2: combine and round half up by 2^-15; unit twiddle passes through.
  always_comb begin
    s_re = {m_rc_r[63], m_rc_r} - {m_is_r[63], m_is_r} + 65'sd16384;
    s_im = {m_ic_r[63], m_ic_r} + {m_rs_r[63], m_rs_r} + 65'sd16384;
    if (byp1_r) begin
      t_re_nxt = {q1_re_r[47], q1_re_r};
      t_im_nxt = {q1_im_r[47], q1_im_r};
    end else begin
      t_re_nxt = s_re[63:15];
      t_im_nxt = s_im[63:15];
    end
  end

  always_ff @(posedge clk) begin
    t_re_r  <= t_re_nxt;
    t_im_r  <= t_im_nxt;
    p2_re_r <= p1_re_r;
    p2_im_r <= p1_im_r;
  end

  // Stage 3: saturated sum and difference.
  always_comb begin
    sum_re = {{2{p2_re_r[47]}}, p2_re_r} + {t_re_r[48], t_re_r};
    sum_im = {{2{p2_im_r[47]}}, p2_im_r} + {t_im_r[48], t_im_r};
    dif_re = {{2{p2_re_r[47]}}, p2_re_r} - {t_re_r[48], t_re_r};
    dif_im = {{2{p2_im_r[47]}}, p2_im_r} - {t_im_r[48], t_im_r};
  end

  always_ff @(posedge clk) begin
    x_re <= fcv_pkg::sat_dw({{14{sum_re[49]}}, sum_re});
    x_im <= fcv_pkg::sat_dw({{14{sum_im[49]}}, sum_im});
    y_re <= fcv_pkg::sat_dw({{14{dif_re[49]}}, dif_re});
    y_im <= fcv_pkg::sat_dw({{14{dif_im[49]}}, dif_im});
  end

endmodule
`default_nettype wire

// ----- rtl/fcv_pmul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fcv_pmul: pipelined complex point product
// Clamps both spectra, multiplies, then combines with 48-bit saturation.
// ----------------------------------------------------------------------------
module fcv_pmul (
  input  wire logic           clk,
  input  wire fcv_pkg::data_t a_re,
  input  wire fcv_pkg::data_t a_im,
  input  wire fcv_pkg::data_t b_re,
  input  wire fcv_pkg::data_t b_im,
  output fcv_pkg::data_t      r_re,
  output fcv_pkg::data_t      r_im
);

  logic signed [fcv_pkg::SPEC_W-1:0] ar, ai, br, bi;
  logic signed [61:0] m_rr_r, m_ii_r, m_ir_r, m_ri_r;
  logic signed [62:0] c_re, c_im;

  // Stage 1: clamp to the spectrum width and form the four products.
  always_comb begin
    ar = fcv_pkg::sat_spec(a_re);
    ai = fcv_pkg::sat_spec(a_im);
    br = fcv_pkg::sat_spec(b_re);
    bi = fcv_pkg::sat_spec(b_im);
  end

  always_ff @(posedge clk) begin
    m_rr_r <= ar * br;
    m_ii_r <= ai * bi;
    m_ir_r <= ai * br;
    m_ri_r <= ar * bi;
  end

  // Stage 2: real and imaginary parts, saturated.
  always_comb begin
    c_re = {m_rr_r[61], m_rr_r} - {m_ii_r[61], m_ii_r};
    c_im = {m_ir_r[61], m_ir_r} + {m_ri_r[61], m_ri_r};
  end

  always_ff @(posedge clk) begin
    r_re <= fcv_pkg::sat_dw({c_re[62], c_re});
    r_im <= fcv_pkg::sat_dw({c_im[62], c_im});
  end

endmodule
`default_nettype wire

// ----- rtl/fft_linear_convolution_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fft_linear_convolution_top: linear convolution through a radix-2 FFT
// Loads two real sequences, transforms both, multiplies the spectra, takes
// the inverse transform and streams out the rounded convolution values.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_ready  | in_func, in_sample
//  out     | output    | out_valid/out_ready| out_conv_value, out_index, out_last
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  Samples are taken while idle. The transfer that completes both sequences
//  starts a job on n points (n = next power of two >= len_a+len_b-1): a
//  bit-reverse pass (each index read with its bit-reversed partner, the pair
//  written back swapped, an index already swapped skipped) ahead of the
//  joint forward FFT and again ahead of the inverse. The butterflies of each
//  transform, the point products and the results go one at a time through the
//  single read port of each work memory. Input is held off during a job;
//  output stalls only extend the result phase. Reset needs no clearing pass.
// ----------------------------------------------------------------------------
module fft_linear_convolution_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_func,
  input  wire logic signed [fcv_pkg::SMP_W-1:0] in_sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [fcv_pkg::OUT_W-1:0]      out_conv_value,
  output logic [fcv_pkg::AW-1:0]                out_index,
  output logic                                  out_last,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic                             cfg_index,
  input  wire logic [fcv_pkg::LEN_W-1:0]        cfg_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_BR_RA = 5'd1;
  localparam logic [4:0] S_BR_RB = 5'd2;
  localparam logic [4:0] S_BR_W1 = 5'd3;
  localparam logic [4:0] S_BR_W2 = 5'd4;
  localparam logic [4:0] S_BF_RP = 5'd5;
  localparam logic [4:0] S_BF_RQ = 5'd6;
  localparam logic [4:0] S_BF_M  = 5'd7;
  localparam logic [4:0] S_BF_S1 = 5'd8;
  localparam logic [4:0] S_BF_S2 = 5'd9;
  localparam logic [4:0] S_BF_WP = 5'd10;
  localparam logic [4:0] S_BF_WQ = 5'd11;
  localparam logic [4:0] S_PM_RD = 5'd12;
  localparam logic [4:0] S_PM_M  = 5'd13;
  localparam logic [4:0] S_PM_S  = 5'd14;
  localparam logic [4:0] S_PM_W  = 5'd15;
  localparam logic [4:0] S_OUT_RD = 5'd16;
  localparam logic [4:0] S_OUT_LD = 5'd17;
  localparam logic [4:0] S_OUT_WT = 5'd18;

  localparam logic CFG_LEN_A = 1'b0;
  localparam logic CFG_LEN_B = 1'b1;

  localparam int AW = fcv_pkg::AW;
  localparam int LW = fcv_pkg::LEN_W;
  localparam int WW = fcv_pkg::WORD_W;
  localparam int DW = fcv_pkg::DW;

  logic [4:0]    state_r, state_nxt;
  logic [LW-1:0] len_a_r, len_b_r;
  logic [LW-1:0] cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [LW-1:0] la_r, lb_r, tot_r;
  logic [LW-1:0] la_nxt, lb_nxt, tot_nxt, lb_max;
  logic [2:0]    lg_r, lg_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [4:0]    bf_r, bf_nxt;
  logic [2:0]    stg_r, stg_nxt;
  logic          inv_r, inv_nxt;
  logic [WW-1:0] vi_a_r, vi_b_r, pl_a_r, pl_b_r, qh_a_r, qh_b_r;

  logic          out_valid_r;
  logic signed [fcv_pkg::OUT_W-1:0] out_val_r;
  logic [AW-1:0] out_idx_r;
  logic          out_last_r;

  logic          acc_in, acc_out, fire;
  logic          we_a, we_b;
  logic [AW-1:0] waddr_a, waddr_b, raddr;
  logic [WW-1:0] wdata_a, wdata_b, rdata_a, rdata_b;
  logic [AW-1:0] rev_full, rev_idx, nm1, half, hmask, p_addr, q_addr, bf6, jsh;
  logic [6:0]    nh;
  logic          bf_last;
  fcv_pkg::tw_t  tw;
  fcv_pkg::data_t xa_re, xa_im, ya_re, ya_im, xb_re, xb_im, yb_re, yb_im;
  fcv_pkg::data_t pm_re, pm_im;
  fcv_pkg::data_t o_re;
  logic signed [48:0] o_sum, o_sh;
  logic signed [fcv_pkg::OUT_W-1:0] o_sat;
  logic [WW-1:0] ld_word;

  // Handshake qualifiers.
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc_in    = in_valid && in_ready;
  assign acc_out   = out_valid_r && out_ready;

  assign out_valid      = out_valid_r;
  assign out_conv_value = out_val_r;
  assign out_index      = out_idx_r;
  assign out_last       = out_last_r;

  // Clamped lengths, result count and transform order.
  always_comb begin
    if (len_a_r == '0) begin
      la_nxt = 7'd1;
    end else if (len_a_r > 7'd64) begin
      la_nxt = 7'd64;
    end else begin
      la_nxt = len_a_r;
    end
    lb_max = 7'd65 - la_nxt;
    if (len_b_r == '0) begin
      lb_nxt = 7'd1;
    end else if (len_b_r > lb_max) begin
      lb_nxt = lb_max;
    end else begin
      lb_nxt = len_b_r;
    end
    tot_nxt = la_nxt + lb_nxt - 7'd1;
    if (tot_nxt <= 7'd1) begin
      lg_nxt = 3'd0;
    end else if (tot_nxt <= 7'd2) begin
      lg_nxt = 3'd1;
    end else if (tot_nxt <= 7'd4) begin
      lg_nxt = 3'd2;
    end else if (tot_nxt <= 7'd8) begin
      lg_nxt = 3'd3;
    end else if (tot_nxt <= 7'd16) begin
      lg_nxt = 3'd4;
    end else if (tot_nxt <= 7'd32) begin
      lg_nxt = 3'd5;
    end else begin
      lg_nxt = 3'd6;
    end
  end

  // Sample counts after this transfer, and job start.
  always_comb begin
    cnt_a_nxt = cnt_a_r;
    cnt_b_nxt = cnt_b_r;
    if (acc_in && !in_func && cnt_a_r < la_nxt) begin
      cnt_a_nxt = cnt_a_r + 7'd1;
    end
    if (acc_in && in_func && cnt_b_r < lb_nxt) begin
      cnt_b_nxt = cnt_b_r + 7'd1;
    end
    fire = acc_in && (cnt_a_nxt >= la_nxt) && (cnt_b_nxt >= lb_nxt);
  end

  // Address arithmetic for the bit-reverse pass and the butterflies.
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      rev_full[b] = idx_r[AW-1-b];
    end
    rev_idx = rev_full >> (3'd6 - lg_r);
    nh      = (7'd1 << lg_r) >> 1;
    nm1     = AW'((7'd1 << lg_r) - 7'd1);
    half    = AW'(1) << (stg_r - 3'd1);
    hmask   = half - AW'(1);
    bf6     = {1'b0, bf_r};
    p_addr  = ((bf6 & ~hmask) << 1) | (bf6 & hmask);
    q_addr  = p_addr | half;
    jsh     = (bf6 & hmask) << (3'd6 - stg_r);
    bf_last = ({2'b0, bf_r} == (nh - 7'd1));
    tw      = fcv_pkg::twiddle(jsh[4:0], inv_r);
  end

  // Result value: divide by n with rounding, saturate to the output width.
  always_comb begin
    o_re  = rdata_a[WW-1:DW];
    o_sum = {o_re[DW-1], o_re};
    if (lg_r != 3'd0) begin
      o_sum = o_sum + (49'sd1 <<< (lg_r - 3'd1));
    end
    o_sh = o_sum >>> lg_r;
    if (o_sh > 49'sh00_7F_FFFF_FFFF) begin
      o_sat = 40'sh7F_FFFF_FFFF;
    end else if (o_sh < -49'sh00_80_0000_0000) begin
      o_sat = -40'sh80_0000_0000;
    end else begin
      o_sat = o_sh[fcv_pkg::OUT_W-1:0];
    end
  end

  assign ld_word = {{(DW-fcv_pkg::SMP_W){in_sample[fcv_pkg::SMP_W-1]}}, in_sample,
                    {DW{1'b0}}};

  // Memory port selection by state. Zero padding applies to the forward pass
  // only; the inverse pass reorders the point products as they stand.
  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr_a = idx_r;
    waddr_b = idx_r;
    wdata_a = ld_word;
    wdata_b = ld_word;
    raddr   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        we_a    = acc_in && !in_func && cnt_a_r < la_nxt;
        we_b    = acc_in && in_func && cnt_b_r < lb_nxt;
        waddr_a = cnt_a_r[AW-1:0];
        waddr_b = cnt_b_r[AW-1:0];
      end
      S_BR_RA: raddr = idx_r;
      S_BR_RB: raddr = rev_idx;
      S_BR_W1: begin
        we_a    = 1'b1;
        we_b    = !inv_r;
        wdata_a = (!inv_r && ({1'b0, rev_idx} >= la_r)) ? '0 : rdata_a;
        wdata_b = ({1'b0, rev_idx} >= lb_r) ? '0 : rdata_b;
      end
      S_BR_W2: begin
        we_a    = 1'b1;
        we_b    = !inv_r;
        waddr_a = rev_idx;
        waddr_b = rev_idx;
        wdata_a = (!inv_r && ({1'b0, idx_r} >= la_r)) ? '0 : vi_a_r;
        wdata_b = ({1'b0, idx_r} >= lb_r) ? '0 : vi_b_r;
      end
      S_BF_RP: raddr = p_addr;
      S_BF_RQ: raddr = q_addr;
      S_BF_M, S_BF_S1, S_BF_S2: raddr = q_addr;
      S_BF_WP: begin
        we_a    = 1'b1;
        we_b    = !inv_r;
        waddr_a = p_addr;
        waddr_b = p_addr;
        wdata_a = {xa_re, xa_im};
        wdata_b = {xb_re, xb_im};
      end
      S_BF_WQ: begin
        we_a    = 1'b1;
        we_b    = !inv_r;
        waddr_a = q_addr;
        waddr_b = q_addr;
        wdata_a = qh_a_r;
        wdata_b = qh_b_r;
      end
      S_PM_RD, S_PM_M, S_PM_S: raddr = idx_r;
      S_PM_W: begin
        we_a    = 1'b1;
        wdata_a = {pm_re, pm_im};
      end
      S_OUT_RD, S_OUT_LD, S_OUT_WT: raddr = idx_r;
      default: raddr = idx_r;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    bf_nxt    = bf_r;
    stg_nxt   = stg_r;
    inv_nxt   = inv_r;
    unique case (state_r)
      S_IDLE: begin
        if (fire) begin
          idx_nxt   = '0;
          inv_nxt   = 1'b0;
          state_nxt = S_BR_RA;
        end
      end
      S_BR_RA: begin
        if (rev_idx < idx_r) begin
          if (idx_r == nm1) begin
            idx_nxt = '0;
            bf_nxt  = '0;
            stg_nxt = 3'd1;
            state_nxt = (lg_r == 3'd0) ? S_PM_RD : S_BF_RP;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end else begin
          state_nxt = S_BR_RB;
        end
      end
      S_BR_RB: state_nxt = S_BR_W1;
      S_BR_W1: state_nxt = S_BR_W2;
      S_BR_W2: begin
        if (idx_r == nm1) begin
          idx_nxt = '0;
          bf_nxt  = '0;
          stg_nxt = 3'd1;
          state_nxt = (lg_r == 3'd0) ? S_PM_RD : S_BF_RP;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_BR_RA;
        end
      end
      S_BF_RP: state_nxt = S_BF_RQ;
      S_BF_RQ: state_nxt = S_BF_M;
      S_BF_M:  state_nxt = S_BF_S1;
      S_BF_S1: state_nxt = S_BF_S2;
      S_BF_S2: state_nxt = S_BF_WP;
      S_BF_WP: state_nxt = S_BF_WQ;
      S_BF_WQ: begin
        state_nxt = S_BF_RP;
        if (bf_last) begin
          bf_nxt = '0;
          if (stg_r == lg_r) begin
            idx_nxt   = '0;
            state_nxt = inv_r ? S_OUT_RD : S_PM_RD;
          end else begin
            stg_nxt = stg_r + 3'd1;
          end
        end else begin
          bf_nxt = bf_r + 5'd1;
        end
      end
      S_PM_RD: state_nxt = S_PM_M;
      S_PM_M:  state_nxt = S_PM_S;
      S_PM_S:  state_nxt = S_PM_W;
      S_PM_W: begin
        if (idx_r == nm1) begin
          idx_nxt = '0;
          if (lg_r == 3'd0) begin
            state_nxt = S_OUT_RD;
          end else begin
            inv_nxt   = 1'b1;
            state_nxt = S_BR_RA;
          end
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_PM_RD;
        end
      end
      S_OUT_RD: state_nxt = S_OUT_LD;
      S_OUT_LD: state_nxt = S_OUT_WT;
      S_OUT_WT: begin
        if (acc_out) begin
          if ({1'b0, idx_r} == tot_r - 7'd1) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_a_r     <= 7'd1;
      len_b_r     <= 7'd1;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      bf_r        <= '0;
      stg_r       <= 3'd1;
      inv_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      bf_r    <= bf_nxt;
      stg_r   <= stg_nxt;
      inv_r   <= inv_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_LEN_A) begin
          len_a_r <= cfg_data;
        end else if (cfg_index == CFG_LEN_B) begin
          len_b_r <= cfg_data;
        end
      end
      if (state_r == S_OUT_WT && acc_out && state_nxt == S_IDLE) begin
        cnt_a_r <= '0;
        cnt_b_r <= '0;
      end else begin
        cnt_a_r <= cnt_a_nxt;
        cnt_b_r <= cnt_b_nxt;
      end
      if (state_r == S_OUT_LD) begin
        out_valid_r <= 1'b1;
      end else if (acc_out) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Job parameters, operand latches and the result register.
  always_ff @(posedge clk) begin
    if (fire) begin
      la_r  <= la_nxt;
      lb_r  <= lb_nxt;
      tot_r <= tot_nxt;
      lg_r  <= lg_nxt;
    end
    if (state_r == S_BR_RB) begin
      vi_a_r <= rdata_a;
      vi_b_r <= rdata_b;
    end
    if (state_r == S_BF_RQ) begin
      pl_a_r <= rdata_a;
      pl_b_r <= rdata_b;
    end
    if (state_r == S_BF_WP) begin
      qh_a_r <= {ya_re, ya_im};
      qh_b_r <= {yb_re, yb_im};
    end
    if (state_r == S_OUT_LD) begin
      out_val_r  <= o_sat;
      out_idx_r  <= idx_r;
      out_last_r <= ({1'b0, idx_r} == tot_r - 7'd1);
    end
  end

  // Work memories: first sequence (also product and inverse), second sequence.
  fcv_ram #(.W(WW), .D(fcv_pkg::MAX_POINTS)) u_mem_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (waddr_a),
    .wdata (wdata_a),
    .raddr (raddr),
    .rdata (rdata_a)
  );

  fcv_ram #(.W(WW), .D(fcv_pkg::MAX_POINTS)) u_mem_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (waddr_b),
    .wdata (wdata_b),
    .raddr (raddr),
    .rdata (rdata_b)
  );

  // Butterfly units, run in lockstep for the two forward transforms.
  fcv_bfly u_bfly_a (
    .clk  (clk),
    .p_re (pl_a_r[WW-1:DW]),
    .p_im (pl_a_r[DW-1:0]),
    .q_re (rdata_a[WW-1:DW]),
    .q_im (rdata_a[DW-1:0]),
    .tw   (tw),
    .x_re (xa_re),
    .x_im (xa_im),
    .y_re (ya_re),
    .y_im (ya_im)
  );

  fcv_bfly u_bfly_b (
    .clk  (clk),
    .p_re (pl_b_r[WW-1:DW]),
    .p_im (pl_b_r[DW-1:0]),
    .q_re (rdata_b[WW-1:DW]),
    .q_im (rdata_b[DW-1:0]),
    .tw   (tw),
    .x_re (xb_re),
    .x_im (xb_im),
    .y_re (yb_re),
    .y_im (yb_im)
  );

  // Point product of the two spectra.
  fcv_pmul u_pmul (
    .clk  (clk),
    .a_re (rdata_a[WW-1:DW]),
    .a_im (rdata_a[DW-1:0]),
    .b_re (rdata_b[WW-1:DW]),
    .b_im (rdata_b[DW-1:0]),
    .r_re (pm_re),
    .r_im (pm_im)
  );

endmodule
`default_nettype wire
